FILE: rtl/ece_pkg.sv
// Shared types, constants and functions of the easing curve evaluator.
package ece_pkg;

   localparam int unsigned ECE_FRAC_BITS = 16;
   localparam int unsigned ECE_SINE_DEPTH = 256;

   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [63:0] Q30_ONE_WIDE = 64'h0000_0000_4000_0000;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Horner divisors of the Taylor series of sin, highest term first
   localparam logic [7:0] TAYLOR_DIV [6] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

   typedef enum logic [3:0] {
      CURVE_LINEAR      = 4'd0,
      CURVE_QUAD_IN     = 4'd1,
      CURVE_QUAD_OUT    = 4'd2,
      CURVE_QUAD_INOUT  = 4'd3,
      CURVE_CUBIC_IN    = 4'd4,
      CURVE_CUBIC_OUT   = 4'd5,
      CURVE_CUBIC_INOUT = 4'd6,
      CURVE_QUART_IN    = 4'd7,
      CURVE_QUART_OUT   = 4'd8,
      CURVE_QUART_INOUT = 4'd9,
      CURVE_QUINT_IN    = 4'd10,
      CURVE_QUINT_OUT   = 4'd11,
      CURVE_QUINT_INOUT = 4'd12,
      CURVE_SINE_IN     = 4'd13,
      CURVE_SINE_OUT    = 4'd14,
      CURVE_SINE_INOUT  = 4'd15
   } curve_type;

   typedef enum logic [1:0] {
      FORM_IN    = 2'd0,
      FORM_OUT   = 2'd1,
      FORM_INOUT = 2'd2
   } form_type;

   typedef struct packed {
      logic       is_sine;
      logic [2:0] order;   // power of the polynomial; linear is order one
      form_type   form;
      logic       poly_hi; // second half of a polynomial in-out curve
      logic       sine_hi; // second half of the sine in-out curve
   } curve_ctl_type;

   function automatic curve_ctl_type decode_curve(input curve_type sel);
      curve_ctl_type ctl;
      ctl = '0;
      case (sel)
         CURVE_LINEAR:      begin ctl.order = 3'd1; ctl.form = FORM_IN; end
         CURVE_QUAD_IN:     begin ctl.order = 3'd2; ctl.form = FORM_IN; end
         CURVE_QUAD_OUT:    begin ctl.order = 3'd2; ctl.form = FORM_OUT; end
         CURVE_QUAD_INOUT:  begin ctl.order = 3'd2; ctl.form = FORM_INOUT; end
         CURVE_CUBIC_IN:    begin ctl.order = 3'd3; ctl.form = FORM_IN; end
         CURVE_CUBIC_OUT:   begin ctl.order = 3'd3; ctl.form = FORM_OUT; end
         CURVE_CUBIC_INOUT: begin ctl.order = 3'd3; ctl.form = FORM_INOUT; end
         CURVE_QUART_IN:    begin ctl.order = 3'd4; ctl.form = FORM_IN; end
         CURVE_QUART_OUT:   begin ctl.order = 3'd4; ctl.form = FORM_OUT; end
         CURVE_QUART_INOUT: begin ctl.order = 3'd4; ctl.form = FORM_INOUT; end
         CURVE_QUINT_IN:    begin ctl.order = 3'd5; ctl.form = FORM_IN; end
         CURVE_QUINT_OUT:   begin ctl.order = 3'd5; ctl.form = FORM_OUT; end
         CURVE_QUINT_INOUT: begin ctl.order = 3'd5; ctl.form = FORM_INOUT; end
         CURVE_SINE_IN:     begin ctl.is_sine = 1'b1; ctl.order = 3'd1; ctl.form = FORM_IN; end
         CURVE_SINE_OUT:    begin ctl.is_sine = 1'b1; ctl.order = 3'd1; ctl.form = FORM_OUT; end
         CURVE_SINE_INOUT:  begin
            ctl.is_sine = 1'b1;
            ctl.order = 3'd1;
            ctl.form = FORM_INOUT;
         end
         default:           begin ctl.order = 3'd1; ctl.form = FORM_IN; end
      endcase
      return ctl;
   endfunction

   // sin(x) in Q30 for an angle x in Q30, evaluated at elaboration for the table
   function automatic logic [30:0] sine_entry(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] r;
      logic [63:0] term;
      x2 = (x * x) >> 30;
      r = Q30_ONE_WIDE;
      for (int i = 0; i < 6; i++) begin
         term = ((x2 * r) >> 30) / 64'(TAYLOR_DIV[i]);
         r = (term < Q30_ONE_WIDE) ? Q30_ONE_WIDE - term : 64'd0;
      end
      r = (x * r) >> 30;
      if (r > Q30_ONE_WIDE) begin
         r = Q30_ONE_WIDE;
      end
      return r[30:0];
   endfunction

endpackage

FILE: rtl/ece_req_if.sv
// Request channel: one normalized time sample per item.
interface ece_req_if
   import ece_pkg::*;
#(
   parameter int unsigned WIDTH = ECE_FRAC_BITS + 1
) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] time_in;

   modport source (output valid, output time_in, input ready);
   modport sink (input valid, input time_in, output ready);
endinterface

FILE: rtl/ece_rsp_if.sv
// Response channel: one eased progress value per item.
interface ece_rsp_if
   import ece_pkg::*;
#(
   parameter int unsigned WIDTH = ECE_FRAC_BITS + 1
) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] progress_out;

   modport source (output valid, output progress_out, input ready);
   modport sink (input valid, input progress_out, output ready);
endinterface

FILE: rtl/easing_curve_evaluator.sv
// Pipelined easing curve evaluator: polynomial and quarter-wave sine curves.
//
//   channel   direction   payload                    handshake
//   req_if    in          time_in      [FRAC_BITS:0] valid / ready
//   rsp_if    out         progress_out [FRAC_BITS:0] valid / ready
//   csr       in          csr_wdata    [3:0]         csr_we, no read-back
//
// One item per cycle while rsp_if.ready is high; seven register stages lie between
// req_if and rsp_if. The four chained rounding multiplies of
// the quintic set the depth; the sine table read and its interpolation
// multiply run alongside.
// Reset clears the stage valid bits and selects the linear curve.
// Each stage holds only while the one after it is full and stalled, so
// bubbles collapse and ready stays high until the whole pipe is full.
module easing_curve_evaluator
   import ece_pkg::*;
#(
   parameter int unsigned FRAC_BITS = ECE_FRAC_BITS,
   parameter int unsigned SINE_TABLE_DEPTH = ECE_SINE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic [3:0]     csr_wdata,
   ece_req_if.sink        req_if,
   ece_rsp_if.source      rsp_if
);

   localparam int unsigned TW = FRAC_BITS + 1;
   localparam int unsigned NSTG = 7;
   localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int unsigned BANK_N = (SINE_TABLE_DEPTH + 1) / 2 + 1;
   localparam int unsigned ADDR_W = $clog2(BANK_N);
   localparam int unsigned POS_W = TW + IDX_W;
   localparam int unsigned PROD_W = 32 + FRAC_BITS;
   localparam logic [TW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [TW-1:0] HALF = ONE >> 1;
   localparam logic [31:0] SINE_RND = 32'd1 << (29 - FRAC_BITS);

   function automatic logic [TW-1:0] mul_round(input logic [TW-1:0] p,
                                               input logic [TW-1:0] x);
      logic [2*TW-1:0] prod;
      prod = {{TW{1'b0}}, p} * {{TW{1'b0}}, x} + (2*TW)'(HALF);
      return prod[FRAC_BITS +: TW];
   endfunction

   function automatic logic [30:0] rom_value(input int unsigned k,
                                             input logic [63:0] angle);
      if (k == 0 || k > SINE_TABLE_DEPTH) begin
         return 31'd0;
      end
      if (k == SINE_TABLE_DEPTH) begin
         return Q30_ONE;
      end
      return sine_entry(angle);
   endfunction

   // Quarter-wave table split into even and odd entries so that two
   // neighbors come out in one read.
   logic [30:0] even_rom [BANK_N];
   logic [30:0] odd_rom [BANK_N];

   for (genvar g = 0; g < BANK_N; g++) begin : g_rom
      localparam int unsigned KE = 2 * g;
      localparam int unsigned KO = 2 * g + 1;
      localparam logic [63:0] XE =
         (HALF_PI_Q30 * 64'(KE) + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
      localparam logic [63:0] XO =
         (HALF_PI_Q30 * 64'(KO) + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
      assign even_rom[g] = rom_value(KE, XE);
      assign odd_rom[g] = rom_value(KO, XO);
   end

   // control
   curve_type       csr_ff;
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] stg_en;

   // stage 1
   logic [TW-1:0]   t1_ff;
   curve_type       sel1_ff;
   // stage 2
   curve_ctl_type   ctl2_ff;
   logic [TW-1:0]   px2_ff;
   logic [TW-1:0]   pp2_ff;
   logic [ADDR_W-1:0] ea2_ff;
   logic [ADDR_W-1:0] oa2_ff;
   logic            odd2_ff;
   logic [FRAC_BITS-1:0] frac2_ff;
   // stage 3
   curve_ctl_type   ctl3_ff;
   logic [TW-1:0]   px3_ff;
   logic [TW-1:0]   pp3_ff;
   logic [30:0]     even_q3_ff;
   logic [30:0]     odd_q3_ff;
   logic            odd3_ff;
   logic [FRAC_BITS-1:0] frac3_ff;
   // stage 4
   curve_ctl_type   ctl4_ff;
   logic [TW-1:0]   px4_ff;
   logic [TW-1:0]   pp4_ff;
   logic [30:0]     a4_ff;
   logic [PROD_W-1:0] prod4_ff;
   // stage 5
   curve_ctl_type   ctl5_ff;
   logic [TW-1:0]   px5_ff;
   logic [TW-1:0]   pp5_ff;
   logic [30:0]     v5_ff;
   // stage 6
   curve_ctl_type   ctl6_ff;
   logic [TW-1:0]   pp6_ff;
   logic [TW-1:0]   sr6_ff;
   // stage 7
   logic [TW-1:0]   res7_ff;

   // next values
   logic [TW-1:0]   t1_in;
   curve_ctl_type   ctl2_in;
   logic [TW-1:0]   px2_in;
   logic [TW-1:0]   xs2;
   logic [TW:0]     t_dbl;
   logic [POS_W-1:0] pos2;
   logic [IDX_W-1:0] idx2;
   logic [IDX_W:0]  idx_inc2;
   logic [ADDR_W-1:0] ea2_in;
   logic [ADDR_W-1:0] oa2_in;
   logic [TW-1:0]   pp3_in;
   logic [30:0]     a3;
   logic [30:0]     b3;
   logic [30:0]     diff3;
   logic [PROD_W-1:0] prod4_in;
   logic [TW-1:0]   pp4_in;
   logic [PROD_W-1:0] qsum4;
   logic [30:0]     q4;
   logic [31:0]     w4;
   logic [30:0]     v5_in;
   logic [TW-1:0]   pp5_in;
   logic [31:0]     rsum5;
   logic [TW-1:0]   sr6_in;
   logic [TW-1:0]   pp6_in;
   logic [TW:0]     hsum6;
   logic [TW-1:0]   h6;
   logic [TW-1:0]   res7_in;

   // a stage may load when it is empty or the next stage loads too
   always_comb begin
      stg_en[NSTG-1] = !vld_ff[NSTG-1] || rsp_if.ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         stg_en[k] = !vld_ff[k] || stg_en[k+1];
      end
   end

   assign req_if.ready = stg_en[0];
   assign rsp_if.valid = vld_ff[NSTG-1];
   assign rsp_if.progress_out = res7_ff;

   // stage 1: saturate time
   assign t1_in = (req_if.time_in > ONE) ? ONE : req_if.time_in;

   // stage 2: decode curve, polynomial base, sine table address
   always_comb begin
      ctl2_in = decode_curve(sel1_ff);
      ctl2_in.poly_hi = (t1_ff >= HALF);
      ctl2_in.sine_hi = (t1_ff > HALF);
      t_dbl = {t1_ff, 1'b0};
      case (ctl2_in.form)
         FORM_IN:    px2_in = t1_ff;
         FORM_OUT:   px2_in = ONE - t1_ff;
         FORM_INOUT: px2_in = ctl2_in.poly_hi ? TW'({ONE - t1_ff, 1'b0}) : TW'(t_dbl);
         default:    px2_in = t1_ff;
      endcase
      case (ctl2_in.form)
         FORM_IN:    xs2 = ONE - t1_ff;
         FORM_OUT:   xs2 = t1_ff;
         FORM_INOUT: xs2 = ctl2_in.sine_hi ? TW'(t_dbl - {1'b0, ONE})
                                            : TW'({1'b0, ONE} - t_dbl);
         default:    xs2 = t1_ff;
      endcase
      pos2 = POS_W'(xs2) * POS_W'(SINE_TABLE_DEPTH);
      idx2 = pos2[FRAC_BITS +: IDX_W];
      idx_inc2 = {1'b0, idx2} + (IDX_W + 1)'(1);
      ea2_in = ADDR_W'(idx_inc2 >> 1);
      oa2_in = ADDR_W'(idx2 >> 1);
   end

   // stage 3: first multiply; table read registered
   assign pp3_in = (ctl2_ff.order > 3'd1) ? mul_round(pp2_ff, px2_ff) : pp2_ff;

   // stage 4: second multiply; interpolation slope times fraction
   always_comb begin
      a3 = odd3_ff ? odd_q3_ff : even_q3_ff;
      b3 = odd3_ff ? even_q3_ff : odd_q3_ff;
      diff3 = (b3 > a3) ? b3 - a3 : 31'd0;
      prod4_in = PROD_W'(diff3) * PROD_W'(frac3_ff);
      pp4_in = (ctl3_ff.order > 3'd2) ? mul_round(pp3_ff, px3_ff) : pp3_ff;
   end

   // stage 5: third multiply; finish interpolation and fold into the curve
   always_comb begin
      qsum4 = prod4_ff + PROD_W'(HALF);
      q4 = a4_ff + qsum4[FRAC_BITS +: 31];
      w4 = ctl4_ff.sine_hi ? 32'(Q30_ONE) + 32'(q4) : 32'(Q30_ONE - q4);
      case (ctl4_ff.form)
         FORM_IN:    v5_in = Q30_ONE - q4;
         FORM_OUT:   v5_in = q4;
         FORM_INOUT: v5_in = w4[31:1];
         default:    v5_in = q4;
      endcase
      pp5_in = (ctl4_ff.order > 3'd3) ? mul_round(pp4_ff, px4_ff) : pp4_ff;
   end

   // stage 6: fourth multiply; round the sine value to the output format
   always_comb begin
      rsum5 = 32'(v5_ff) + SINE_RND;
      sr6_in = rsum5[(30 - FRAC_BITS) +: TW];
      pp6_in = (ctl5_ff.order > 3'd4) ? mul_round(pp5_ff, px5_ff) : pp5_ff;
   end

   // stage 7: apply the form to the power and pick the curve
   always_comb begin
      hsum6 = {1'b0, pp6_ff} + (TW + 1)'(1);
      h6 = hsum6[TW:1];
      if (ctl6_ff.is_sine) begin
         res7_in = sr6_ff;
      end else begin
         case (ctl6_ff.form)
            FORM_IN:    res7_in = pp6_ff;
            FORM_OUT:   res7_in = ONE - pp6_ff;
            FORM_INOUT: res7_in = ctl6_ff.poly_hi ? ONE - h6 : h6;
            default:    res7_in = pp6_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CURVE_LINEAR;
         vld_ff <= '0;
      end else begin
         if (csr_we) begin
            csr_ff <= curve_type'(csr_wdata);
         end
         if (stg_en[0]) begin
            vld_ff[0] <= req_if.valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (stg_en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en[0]) begin
         t1_ff <= t1_in;
         sel1_ff <= csr_ff;
      end
      if (stg_en[1]) begin
         ctl2_ff <= ctl2_in;
         px2_ff <= px2_in;
         pp2_ff <= px2_in;
         ea2_ff <= ea2_in;
         oa2_ff <= oa2_in;
         odd2_ff <= idx2[0];
         frac2_ff <= pos2[FRAC_BITS-1:0];
      end
      if (stg_en[2]) begin
         ctl3_ff <= ctl2_ff;
         px3_ff <= px2_ff;
         pp3_ff <= pp3_in;
         even_q3_ff <= even_rom[ea2_ff];
         odd_q3_ff <= odd_rom[oa2_ff];
         odd3_ff <= odd2_ff;
         frac3_ff <= frac2_ff;
      end
      if (stg_en[3]) begin
         ctl4_ff <= ctl3_ff;
         px4_ff <= px3_ff;
         pp4_ff <= pp4_in;
         a4_ff <= a3;
         prod4_ff <= prod4_in;
      end
      if (stg_en[4]) begin
         ctl5_ff <= ctl4_ff;
         px5_ff <= px4_ff;
         pp5_ff <= pp5_in;
         v5_ff <= v5_in;
      end
      if (stg_en[5]) begin
         ctl6_ff <= ctl5_ff;
         pp6_ff <= pp6_in;
         sr6_ff <= sr6_in;
      end
      if (stg_en[6]) begin
         res7_ff <= res7_in;
      end
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the easing curve evaluator: directed table, then random phases.
module tb;
   import ece_pkg::*;

   localparam int unsigned FB = ECE_FRAC_BITS;
   localparam int unsigned DEPTH = ECE_SINE_DEPTH;
   localparam int unsigned UNIT = 1 << FB;
   localparam logic [63:0] ONE = 64'(UNIT);
   localparam logic [63:0] HALF = ONE >> 1;
   localparam logic [63:0] Q30 = 64'd1 << 30;
   localparam int unsigned N_DIRECTED = 25;
   localparam int unsigned N_PHASES = 16;
   localparam int unsigned PHASE_ITEMS = 120;
   localparam int unsigned LONG_HOLD = 80;
   localparam int unsigned SETTLE = 20;

   typedef logic [FB:0] fixed_word;

   localparam fixed_word FX_ZERO = '0;
   localparam fixed_word FX_HALF = fixed_word'(UNIT / 2);
   localparam fixed_word FX_ONE = fixed_word'(UNIT);
   localparam fixed_word FX_ALL = '1;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      curve_type curve;
      fixed_word sample;
      logic      known;
      fixed_word want;
   } directed_row;

   typedef struct packed {
      fixed_word sample;
      fixed_word progress;
   } pending_result;

   logic clock;
   logic reset;
   logic csr_we;
   logic [3:0] csr_wdata;

   ece_req_if req_ch ();
   ece_rsp_if rsp_ch ();

   easing_curve_evaluator dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch)
   );

   logic [63:0] sin_q30 [0:DEPTH];
   pending_result progress_queue [$];
   curve_type active_curve;
   idle_mode_type idle_mode;
   logic hold_pending;
   int unsigned fail_count;

   directed_row directed_rows [N_DIRECTED] = '{
      '{CURVE_LINEAR,      FX_ZERO,          1'b1, FX_ZERO},
      '{CURVE_LINEAR,      FX_ONE,           1'b1, FX_ONE},
      '{CURVE_LINEAR,      FX_ALL,           1'b1, FX_ONE},
      '{CURVE_LINEAR,      fixed_word'(1),   1'b1, fixed_word'(1)},
      '{CURVE_LINEAR,      FX_HALF,          1'b1, FX_HALF},
      '{CURVE_QUAD_IN,     FX_ALL,           1'b1, FX_ONE},
      '{CURVE_QUAD_OUT,    FX_ZERO,          1'b1, FX_ZERO},
      '{CURVE_QUAD_INOUT,  FX_HALF,          1'b0, FX_ZERO},
      '{CURVE_QUAD_INOUT,  FX_ALL,           1'b1, FX_ONE},
      '{CURVE_CUBIC_IN,    FX_ZERO,          1'b1, FX_ZERO},
      '{CURVE_CUBIC_OUT,   FX_ALL,           1'b1, FX_ONE},
      '{CURVE_CUBIC_INOUT, FX_ZERO,          1'b1, FX_ZERO},
      '{CURVE_CUBIC_INOUT, FX_HALF,          1'b0, FX_ZERO},
      '{CURVE_QUART_IN,    FX_ONE,           1'b1, FX_ONE},
      '{CURVE_QUART_OUT,   FX_ZERO,          1'b1, FX_ZERO},
      '{CURVE_QUART_INOUT, FX_HALF,          1'b0, FX_ZERO},
      '{CURVE_QUART_INOUT, FX_ONE,           1'b1, FX_ONE},
      '{CURVE_QUINT_IN,    FX_ALL,           1'b1, FX_ONE},
      '{CURVE_QUINT_OUT,   FX_ZERO,          1'b1, FX_ZERO},
      '{CURVE_QUINT_INOUT, FX_HALF - 1'b1,   1'b0, FX_ZERO},
      '{CURVE_QUINT_INOUT, FX_HALF,          1'b0, FX_ZERO},
      '{CURVE_SINE_IN,     FX_ZERO,          1'b1, FX_ZERO},
      '{CURVE_SINE_OUT,    FX_ALL,           1'b1, FX_ONE},
      '{CURVE_SINE_INOUT,  FX_HALF,          1'b0, FX_ZERO},
      '{CURVE_SINE_INOUT,  FX_ALL,           1'b1, FX_ONE}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Quarter-wave sine table in Q30, Horner form of the Taylor series
   initial begin : sine_table_init
      logic [63:0] ang;
      logic [63:0] ang2;
      logic [63:0] acc;
      logic [63:0] term;
      for (int k = 0; k <= DEPTH; k++) begin
         ang = (HALF_PI_Q30 * 64'(k) + 64'(DEPTH / 2)) / 64'(DEPTH);
         ang2 = (ang * ang) >> 30;
         acc = Q30;
         for (int i = 0; i < 6; i++) begin
            term = ((ang2 * acc) >> 30) / 64'(TAYLOR_DIV[i]);
            acc = (term < Q30) ? Q30 - term : 64'd0;
         end
         acc = (ang * acc) >> 30;
         if (acc > Q30) begin
            acc = Q30;
         end
         sin_q30[k] = acc;
      end
      sin_q30[0] = 64'd0;
      sin_q30[DEPTH] = Q30;
   end

   // sin(x * pi/2) in Q30, linear interpolation between table entries
   function automatic logic [63:0] sine_quarter(input logic [63:0] x);
      logic [63:0] pos;
      logic [63:0] idx;
      logic [63:0] frac;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] span;
      if (x > ONE) begin
         x = ONE;
      end
      pos = x * 64'(DEPTH);
      idx = pos >> FB;
      frac = pos & (ONE - 64'd1);
      if (idx >= 64'(DEPTH)) begin
         return sin_q30[DEPTH];
      end
      lo = sin_q30[idx];
      hi = sin_q30[idx + 1];
      span = (hi > lo) ? hi - lo : 64'd0;
      return lo + ((span * frac + HALF) >> FB);
   endfunction

   function automatic logic [63:0] fx_power(input logic [63:0] x, input int unsigned n);
      logic [63:0] p;
      p = x;
      for (int unsigned i = 1; i < n; i++) begin
         p = (p * x + HALF) >> FB;
      end
      return p;
   endfunction

   function automatic fixed_word eased_progress(input curve_type curve, input fixed_word t_in);
      logic [63:0] t;
      logic [63:0] r;
      logic [63:0] v;
      int unsigned order;
      form_type form;
      t = 64'(t_in);
      if (t > ONE) begin
         t = ONE;
      end
      r = t;
      if (curve >= CURVE_SINE_IN) begin
         case (curve)
            CURVE_SINE_IN: v = Q30 - sine_quarter(ONE - t);
            CURVE_SINE_OUT: v = sine_quarter(t);
            default: begin
               if (t <= HALF) begin
                  v = (Q30 - sine_quarter(ONE - (t << 1))) >> 1;
               end else begin
                  v = (Q30 + sine_quarter((t << 1) - ONE)) >> 1;
               end
            end
         endcase
         r = (v + (64'd1 << (29 - FB))) >> (30 - FB);
      end else if (curve != CURVE_LINEAR) begin
         order = 2 + (int'(curve) - 1) / 3;
         form = form_type'((int'(curve) - 1) % 3);
         case (form)
            FORM_IN: r = fx_power(t, order);
            FORM_OUT: r = ONE - fx_power(ONE - t, order);
            default: begin
               if (t < HALF) begin
                  r = (fx_power(t << 1, order) + 64'd1) >> 1;
               end else begin
                  r = ONE - ((fx_power((ONE - t) << 1, order) + 64'd1) >> 1);
               end
            end
         endcase
      end
      if (r > ONE) begin
         r = ONE;
      end
      return r[FB:0];
   endfunction

   task automatic report_mismatch(input string what, input fixed_word sample,
                                  input fixed_word got, input fixed_word want);
      $display("MISMATCH %s: time_in %0d progress %0d, wanted %0d at %0t",
               what, sample, got, want, $time);
      fail_count++;
   endtask

   task automatic write_curve(input curve_type curve);
      csr_we <= 1'b1;
      csr_wdata <= curve;
      @(posedge clock);
      csr_we <= 1'b0;
      active_curve = curve;
   endtask

   // Drop valid and wait until every pending result is back
   task automatic drain_pipe();
      req_ch.valid <= 1'b0;
      while (progress_queue.size() != 0) @(posedge clock);
   endtask

   task automatic send_sample(input fixed_word t, input logic known, input fixed_word want);
      int unsigned gap_pct;
      pending_result entry;
      gap_pct = (idle_mode == IDLE_SENDER) ? 80 : (idle_mode == IDLE_BOTH) ? 36 : 0;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < gap_pct) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.time_in <= t;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      entry.sample = t;
      entry.progress = known ? want : eased_progress(active_curve, t);
      progress_queue.push_back(entry);
   endtask

   initial begin : receiver
      int unsigned hold_left;
      int unsigned stall_pct;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left = LONG_HOLD;
         end
         stall_pct = (idle_mode == IDLE_RECEIVER) ? 80 : (idle_mode == IDLE_BOTH) ? 36 : 0;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      pending_result head;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (progress_queue.size() == 0) begin
            report_mismatch("unexpected item", FX_ZERO, rsp_ch.progress_out, FX_ZERO);
         end else begin
            head = progress_queue.pop_front();
            if (rsp_ch.progress_out !== head.progress) begin
               report_mismatch("progress_out", head.sample, rsp_ch.progress_out,
                               head.progress);
            end
         end
      end
   end

   initial begin : stimulus
      fixed_word t;
      int unsigned roll;
      int unsigned landmark;
      int unsigned wait_count;
      req_ch.valid <= 1'b0;
      req_ch.time_in <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      reset <= 1'b1;
      idle_mode = IDLE_NONE;
      hold_pending = 1'b0;
      fail_count = 0;
      active_curve = CURVE_LINEAR;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // The first rows run on the curve selected by reset
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i].curve != active_curve) begin
            drain_pipe();
            write_curve(directed_rows[i].curve);
         end
         send_sample(directed_rows[i].sample, directed_rows[i].known, directed_rows[i].want);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         drain_pipe();
         idle_mode = idle_mode_type'(p % 4);
         write_curve(curve_type'((p * 7) % 16));
         // Hold off the receiver so the pipe fills and stalls the input
         if (p % 8 == 4) begin
            hold_pending = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               t = fixed_word'($urandom_range(0, UNIT));
            end else if (roll < 82) begin
               landmark = $urandom_range(0, 2) * (UNIT / 2);
               t = fixed_word'(landmark + $urandom_range(0, 6) - 3);
            end else if (roll < 92) begin
               t = fixed_word'($urandom_range(UNIT + 1, 2 * UNIT - 1));
            end else begin
               t = fixed_word'($urandom);
            end
            send_sample(t, 1'b0, FX_ZERO);
         end
      end

      req_ch.valid <= 1'b0;
      for (wait_count = 0; progress_queue.size() != 0 && wait_count < 20000; wait_count++) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
      if (progress_queue.size() != 0) begin
         report_mismatch("missing item", progress_queue[0].sample, FX_ZERO,
                         progress_queue[0].progress);
      end
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
